/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define DRR_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("drr assertion failed");

// Check that a condition in one cycle implies another in the same cycle.
`define DRR_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("drr implication failed");

`endif

/* rtl/drr_pkg.sv */
`timescale 1ns / 1ps
package drr_pkg;
	localparam int ZONES         = 2;
	localparam int POTS_PER_ZONE = 10;
	localparam int HISTORY_DEPTH = 16;

	localparam int SLOTS     = ZONES * POTS_PER_ZONE;
	localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int POS_W     = $clog2(HISTORY_DEPTH);
	localparam int MEM_DEPTH = SLOTS * HISTORY_DEPTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	localparam int CNT_W    = 5;
	localparam int RATE_W   = 11;
	localparam int STATUS_W = 3;
	localparam int HUM_W    = 8;
	localparam int TIME_W   = 32;

	localparam int MIN_SAMPLES = 6;
	localparam int DEGEN_LIMIT = 16778;
	localparam int RATE_MIN    = 10;
	localparam int RATE_MAX    = 2000;
	// 4096 / 3600000 reduces to 32 / 28125
	localparam int X_DIVISOR   = 28125;
	// 2^46 / 28125 rounded down; dt * X_RECIP >> 41 is the hour value or one below
	localparam int X_SHIFT     = 41;
	localparam logic [31:0] X_RECIP = 32'((64'd1 << 46) / 64'(X_DIVISOR));
	localparam int R_STEPS     = 12;

	localparam int X_W   = 23;
	localparam int SX_W  = 28;
	localparam int SY_W  = 12;
	localparam int SXY_W = 35;
	localparam int SXX_W = 51;
	localparam int DEN_W = 57;
	localparam int NUM_W = 41;
	localparam int DVD_W = 64;
	localparam int DVS_W = 56;

	typedef enum logic [STATUS_W-1:0] {
		ST_RECORDED = 3'd0,
		ST_UPDATED  = 3'd1,
		ST_FEW      = 3'd2,
		ST_DEGEN    = 3'd3,
		ST_BADIDX   = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_BASE, S_READ, S_LOAD, S_XFIX, S_ACC,
		S_F1, S_F2, S_F3, S_F4, S_DIVR, S_FINISH
	} state_t;

	typedef struct packed {
		logic    ld_in;
		logic    rec;
		logic    rd_first;
		logic    ld_base;
		logic    rd_ptr;
		logic    est_x;
		logic    fix_x;
		logic    acc;
		logic    fin1;
		logic    fin2;
		logic    fin3;
		logic    div_r;
		logic    rate_min;
		logic    rate_div;
		logic    st_ld;
		status_t st_code;
		logic    out_ld;
	} dp_cmd_t;

	typedef struct packed {
		logic bad;
		logic is_upd;
		logic few;
		logic k_last;
		logic div_done;
		logic degen;
		logic nonpos;
		logic out_busy;
	} dp_stat_t;
endpackage

/* rtl/drr_div.sv */
`timescale 1ns / 1ps
module drr_div import drr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DVD_W-1:0]   dividend,
	input  logic [DVS_W-1:0]   divisor,
	output logic               done,
	output logic [R_STEPS-1:0] quotient,
	output logic               ovf
);
	logic               busy_q, done_q, ovf_q;
	logic [4:0]         cnt_q;
	logic [DVD_W-1:0]   rem_q;
	logic [66:0]        sh_q;
	logic [R_STEPS-1:0] quo_q;
	logic [66:0]        sh_init;
	logic               ovf_init, ge;

	assign sh_init  = {11'b0, divisor} << (R_STEPS - 1);
	assign ovf_init = {4'b0, dividend} >= ({12'b0, divisor} << R_STEPS);
	assign ge       = {3'b0, rem_q} >= sh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(R_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			sh_q  <= sh_init;
			quo_q <= '0;
			ovf_q <= ovf_init;
		end else if (busy_q) begin
			if (ge)
				rem_q <= rem_q - sh_q[DVD_W-1:0];
			quo_q <= {quo_q[R_STEPS-2:0], ge};
			sh_q  <= sh_q >> 1;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
	assign ovf      = ovf_q;
endmodule

/* rtl/drr_dp.sv */
`timescale 1ns / 1ps
module drr_dp import drr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	output dp_stat_t            stat,
	input  logic                command,
	input  logic [1:0]          zone,
	input  logic [3:0]          pot,
	input  logic [HUM_W-1:0]    humidity,
	input  logic [TIME_W-1:0]   sample_time_ms,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [STATUS_W-1:0] status,
	output logic [RATE_W-1:0]   rate_centipct_per_hour,
	output logic [CNT_W-1:0]    sample_count
);
	logic                cmd_q;
	logic [1:0]          zone_q;
	logic [3:0]          pot_q;
	logic [HUM_W-1:0]    hum_q;
	logic [TIME_W-1:0]   time_q;

	logic [POS_W-1:0]    wp_q   [SLOTS];
	logic [CNT_W-1:0]    held_q [SLOTS];
	logic [RATE_W-1:0]   rate_q [SLOTS];

	logic [HUM_W-1:0]    hum_mem [MEM_DEPTH];
	logic [TIME_W-1:0]   tim_mem [MEM_DEPTH];
	logic [HUM_W-1:0]    hum_rd_q;
	logic [TIME_W-1:0]   tim_rd_q;

	logic [TIME_W-1:0]   base_q;
	logic [POS_W-1:0]    ptr_q, k_q;
	logic [CNT_W-1:0]    n_q;
	logic [HUM_W-1:0]    y_q;
	logic [X_W-1:0]      x_est_q, x_q;
	logic [SX_W-1:0]     sx_q;
	logic [SY_W-1:0]     sy_q;
	logic [SXY_W-1:0]    sxy_q;
	logic [SXX_W-1:0]    sxx_q;
	logic [55:0]         nsxx_q, sx2_q;
	logic [39:0]         nsxy_q, sxsy_q;
	logic signed [DEN_W-1:0] den_q;
	logic signed [NUM_W-1:0] num_q;
	logic [DVD_W-1:0]    dvd_q;
	status_t             status_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [RATE_W-1:0]   out_rate_q;
	logic [CNT_W-1:0]    out_cnt_q;

	logic [6:0]          slot_wide;
	logic [SLOT_W-1:0]   slot;
	logic                bad;
	logic [CNT_W-1:0]    cur_cnt;
	logic [POS_W-1:0]    cur_wp, wp_next, first, ptr_next;
	logic [POS_W:0]      fsum;
	logic [ADDR_W-1:0]   wr_addr, rd_addr;
	logic                rd_en;

	logic                div_done, div_ovf;
	logic [TIME_W-1:0]   dt;
	logic [63:0]         x_prod;
	logic [36:0]         x_back, x_rem;
	logic [X_W-1:0]      x_fix;
	logic [30:0]         xy;
	logic [45:0]         xx;
	logic [55:0]         nsxx, sx2;
	logic [39:0]         nsxy, sxsy;
	logic [NUM_W-1:0]    neg;
	logic [DVD_W-1:0]    neg64, dvd;
	logic [R_STEPS-1:0]  q;
	logic [RATE_W-1:0]   rate_new;

	assign slot_wide = 7'(zone_q) * 7'(POTS_PER_ZONE) + 7'(pot_q);
	assign slot      = slot_wide[SLOT_W-1:0];
	assign bad       = (3'(zone_q) >= 3'(ZONES)) || (5'(pot_q) >= 5'(POTS_PER_ZONE));
	assign cur_cnt   = held_q[slot];
	assign cur_wp    = wp_q[slot];
	assign wp_next   = (cur_wp == POS_W'(HISTORY_DEPTH - 1)) ? '0 : cur_wp + 1'b1;
	assign ptr_next  = (ptr_q == POS_W'(HISTORY_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
	assign fsum      = (POS_W+1)'(cur_wp) + (POS_W+1)'(HISTORY_DEPTH) - (POS_W+1)'(cur_cnt);
	assign first     = (fsum >= (POS_W+1)'(HISTORY_DEPTH))
	                 ? POS_W'(fsum - (POS_W+1)'(HISTORY_DEPTH)) : fsum[POS_W-1:0];

	assign wr_addr = ADDR_W'(int'(slot) * HISTORY_DEPTH + int'(cur_wp));
	assign rd_addr = ADDR_W'(int'(slot) * HISTORY_DEPTH
	                 + int'(cmd.rd_first ? first : ptr_q));
	assign rd_en   = cmd.rd_first || cmd.rd_ptr;

	always_ff @(posedge clk) begin
		if (cmd.rec) begin
			hum_mem[wr_addr] <= hum_q;
			tim_mem[wr_addr] <= time_q;
		end
		if (rd_en) begin
			hum_rd_q <= hum_mem[rd_addr];
			tim_rd_q <= tim_mem[rd_addr];
		end
	end

	// hours since the oldest sample: reciprocal estimate, then one correction step
	assign dt     = tim_rd_q - base_q;
	assign x_prod = 64'(dt) * 64'(X_RECIP);
	assign x_back = 37'(x_est_q) * 37'(X_DIVISOR);
	assign x_rem  = {dt, 5'b0} - x_back;
	assign x_fix  = x_est_q + X_W'(x_rem >= 37'(X_DIVISOR));

	drr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_r),
		.dividend  (dvd_q),
		.divisor   (den_q[DVS_W-1:0]),
		.done      (div_done),
		.quotient  (q),
		.ovf       (div_ovf)
	);

	assign xy   = 31'(x_q) * 31'(y_q);
	assign xx   = 46'(x_q) * 46'(x_q);
	assign nsxx = 56'(n_q) * 56'(sxx_q);
	assign sx2  = 56'(sx_q) * 56'(sx_q);
	assign nsxy = 40'(n_q) * 40'(sxy_q);
	assign sxsy = 40'(sx_q) * 40'(sy_q);
	assign neg  = NUM_W'(-num_q);
	assign neg64 = DVD_W'(neg);
	// times 409600 = 2^18 + 2^17 + 2^14, plus half the divisor for rounding
	assign dvd  = (neg64 << 18) + (neg64 << 17) + (neg64 << 14)
	            + DVD_W'(den_q[DVS_W-1:1]);
	assign rate_new = (div_ovf || q > R_STEPS'(RATE_MAX)) ? RATE_W'(RATE_MAX)
	                : (q < R_STEPS'(RATE_MIN)) ? RATE_W'(RATE_MIN) : q[RATE_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			cmd_q  <= command;
			zone_q <= zone;
			pot_q  <= pot;
			hum_q  <= humidity;
			time_q <= sample_time_ms;
		end
		if (cmd.rd_first) begin
			ptr_q <= first;
			k_q   <= '0;
			n_q   <= cur_cnt;
			sx_q  <= '0;
			sy_q  <= '0;
			sxy_q <= '0;
			sxx_q <= '0;
		end
		if (cmd.ld_base)
			base_q <= tim_rd_q;
		if (cmd.est_x) begin
			x_est_q <= x_prod[X_SHIFT +: X_W];
			y_q     <= hum_rd_q;
		end
		if (cmd.fix_x)
			x_q <= x_fix;
		if (cmd.acc) begin
			sx_q  <= sx_q + SX_W'(x_q);
			sy_q  <= sy_q + SY_W'(y_q);
			sxy_q <= sxy_q + SXY_W'(xy);
			sxx_q <= sxx_q + SXX_W'(xx);
			ptr_q <= ptr_next;
			k_q   <= k_q + 1'b1;
		end
		if (cmd.fin1) begin
			nsxx_q <= nsxx;
			sx2_q  <= sx2;
			nsxy_q <= nsxy;
			sxsy_q <= sxsy;
		end
		if (cmd.fin2) begin
			den_q <= signed'({1'b0, nsxx_q}) - signed'({1'b0, sx2_q});
			num_q <= signed'({1'b0, nsxy_q}) - signed'({1'b0, sxsy_q});
		end
		if (cmd.fin3)
			dvd_q <= dvd;
		if (cmd.st_ld)
			status_q <= cmd.st_code;
		if (cmd.out_ld) begin
			out_status_q <= status_q;
			out_rate_q   <= bad ? '0 : rate_q[slot];
			out_cnt_q    <= bad ? '0 : held_q[slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				wp_q[i]   <= '0;
				held_q[i] <= '0;
				rate_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.rec) begin
				wp_q[slot] <= wp_next;
				if (cur_cnt < CNT_W'(HISTORY_DEPTH))
					held_q[slot] <= cur_cnt + 1'b1;
			end
			if (cmd.rate_min)
				rate_q[slot] <= RATE_W'(RATE_MIN);
			else if (cmd.rate_div)
				rate_q[slot] <= rate_new;
			if (cmd.out_ld)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign stat.bad      = bad;
	assign stat.is_upd   = cmd_q;
	assign stat.few      = cur_cnt < CNT_W'(MIN_SAMPLES);
	assign stat.k_last   = CNT_W'(k_q) == n_q - 1'b1;
	assign stat.div_done = div_done;
	assign stat.degen    = den_q < signed'(DEN_W'(DEGEN_LIMIT));
	assign stat.nonpos   = !num_q[NUM_W-1];
	assign stat.out_busy = out_valid_q && !out_ready;

	assign out_valid              = out_valid_q;
	assign status                 = out_status_q;
	assign rate_centipct_per_hour = out_rate_q;
	assign sample_count           = out_cnt_q;
endmodule

/* rtl/drr_ctrl.sv */
`timescale 1ns / 1ps
module drr_ctrl import drr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.ld_in = 1'b1;
					state_d   = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.bad) begin
					cmd.st_ld   = 1'b1;
					cmd.st_code = ST_BADIDX;
					state_d     = S_FINISH;
				end else if (!stat.is_upd) begin
					cmd.rec     = 1'b1;
					cmd.st_ld   = 1'b1;
					cmd.st_code = ST_RECORDED;
					state_d     = S_FINISH;
				end else if (stat.few) begin
					cmd.st_ld   = 1'b1;
					cmd.st_code = ST_FEW;
					state_d     = S_FINISH;
				end else begin
					cmd.rd_first = 1'b1;
					state_d      = S_BASE;
				end
			end
			S_BASE: begin
				cmd.ld_base = 1'b1;
				state_d     = S_READ;
			end
			S_READ: begin
				cmd.rd_ptr = 1'b1;
				state_d    = S_LOAD;
			end
			S_LOAD: begin
				cmd.est_x = 1'b1;
				state_d   = S_XFIX;
			end
			S_XFIX: begin
				cmd.fix_x = 1'b1;
				state_d   = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = stat.k_last ? S_F1 : S_READ;
			end
			S_F1: begin
				cmd.fin1 = 1'b1;
				state_d  = S_F2;
			end
			S_F2: begin
				cmd.fin2 = 1'b1;
				state_d  = S_F3;
			end
			S_F3: begin
				cmd.fin3 = 1'b1;
				if (stat.degen) begin
					cmd.st_ld   = 1'b1;
					cmd.st_code = ST_DEGEN;
					state_d     = S_FINISH;
				end else if (stat.nonpos) begin
					cmd.rate_min = 1'b1;
					cmd.st_ld    = 1'b1;
					cmd.st_code  = ST_UPDATED;
					state_d      = S_FINISH;
				end else begin
					state_d = S_F4;
				end
			end
			S_F4: begin
				cmd.div_r = 1'b1;
				state_d   = S_DIVR;
			end
			S_DIVR: begin
				if (stat.div_done) begin
					cmd.rate_div = 1'b1;
					cmd.st_ld    = 1'b1;
					cmd.st_code  = ST_UPDATED;
					state_d      = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!stat.out_busy) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

/* rtl/drying_rate_regression.sv */
`timescale 1ns / 1ps
// channel  handshake            payload
// in       in_valid / in_ready  command, zone, pot, humidity, sample_time_ms
// out      out_valid/out_ready  status, rate_centipct_per_hour, sample_count
//
// One item at a time. Record, bad index and too-few-samples items raise out_valid
// from the output register loaded in the finish state that follows the check state.
// An update over n samples raises out_valid once the fit is done: each sample takes
// a read, a reciprocal multiply, a correction and an accumulate; the final slope
// division follows. A degenerate, flat or rising fit skips that division. Reset
// clears slot pointers, counts and rates at once; ring memories are not cleared.
// A stalled result sits in the output register while the next item is accepted;
// that item waits at its last step.
module drying_rate_regression import drr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                command,
	input  logic [1:0]          zone,
	input  logic [3:0]          pot,
	input  logic [HUM_W-1:0]    humidity,
	input  logic [TIME_W-1:0]   sample_time_ms,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [RATE_W-1:0]   rate_centipct_per_hour,
	output logic [CNT_W-1:0]    sample_count
);
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequence record, fit and result load
	drr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// hold rings, slot state, sums and the output register
	drr_dp u_dp (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cmd                    (cmd),
		.stat                   (stat),
		.command                (command),
		.zone                   (zone),
		.pot                    (pot),
		.humidity               (humidity),
		.sample_time_ms         (sample_time_ms),
		.out_ready              (out_ready),
		.out_valid              (out_valid),
		.status                 (status),
		.rate_centipct_per_hour (rate_centipct_per_hour),
		.sample_count           (sample_count)
	);
endmodule

/* rtl/drr_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module drr_checker import drr_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [STATUS_W-1:0] status,
	input logic [RATE_W-1:0]   rate_centipct_per_hour,
	input logic [CNT_W-1:0]    sample_count
);
	`DRR_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid)
	`DRR_ASSERT(a_busy_after_accept, clk, arst_n, in_valid && in_ready |=> !in_ready)
	`DRR_ASSERT_IMPL(a_bad_zero, clk, arst_n, out_valid && status == ST_BADIDX, rate_centipct_per_hour == 0 && sample_count == 0)
	`DRR_ASSERT_IMPL(a_rate_range, clk, arst_n, out_valid && status == ST_UPDATED, rate_centipct_per_hour >= RATE_W'(RATE_MIN) && rate_centipct_per_hour <= RATE_W'(RATE_MAX))
	`DRR_ASSERT_IMPL(a_rec_count, clk, arst_n, out_valid && status == ST_RECORDED, sample_count != 0)
endmodule

bind drying_rate_regression drr_checker u_drr_checker (.*);

/* dv/drying_rate_regression_tb.sv */
`timescale 1ns / 1ps
module drying_rate_regression_tb;
	import drr_pkg::*;

	// One expected result item.
	typedef struct {
		status_t              st;
		logic [RATE_W-1:0]    rate;
		logic [CNT_W-1:0]     count;
	} rate_result_t;

	// Mirror of the per-slot sample rings plus the queue of predicted results.
	class drying_rate_book;
		logic [HUM_W-1:0]  hum_ring [SLOTS][HISTORY_DEPTH];
		logic [TIME_W-1:0] tms_ring [SLOTS][HISTORY_DEPTH];
		int unsigned       wr_pos [SLOTS];
		int unsigned       held [SLOTS];
		int unsigned       rate [SLOTS];
		rate_result_t      expected_results [$];
		int                errors;

		function new();
			errors = 0;
			for (int s = 0; s < SLOTS; s++) begin
				wr_pos[s] = 0;
				held[s] = 0;
				rate[s] = 0;
			end
		endfunction

		// Least-squares slope over the held samples, oldest first.
		function status_t fit(int unsigned s);
			int unsigned first, at;
			logic [TIME_W-1:0] base;
			longint unsigned dt;
			longint sx, sy, sxy, sxx, x, y, n, num, den, neg, q;
			if (held[s] < MIN_SAMPLES) return ST_FEW;
			first = (wr_pos[s] + HISTORY_DEPTH - held[s]) % HISTORY_DEPTH;
			base = tms_ring[s][first];
			sx = 0; sy = 0; sxy = 0; sxx = 0;
			for (int k = 0; k < held[s]; k++) begin
				at = (first + k) % HISTORY_DEPTH;
				dt = 64'(TIME_W'(tms_ring[s][at] - base));
				x = longint'((dt * 4096) / 3600000);
				y = longint'(hum_ring[s][at]);
				sx += x;
				sy += y;
				sxy += x * y;
				sxx += x * x;
			end
			n = longint'(held[s]);
			den = n * sxx - sx * sx;
			if (den < DEGEN_LIMIT) return ST_DEGEN;
			num = n * sxy - sx * sy;
			neg = -num;
			if (neg <= 0) begin
				q = RATE_MIN;
			end else begin
				q = (neg * 409600 + den / 2) / den;
				if (q < RATE_MIN) q = RATE_MIN;
				if (q > RATE_MAX) q = RATE_MAX;
			end
			rate[s] = 32'(q);
			return ST_UPDATED;
		endfunction

		function void note_item(logic cmd, logic [1:0] z, logic [3:0] p,
				logic [HUM_W-1:0] h, logic [TIME_W-1:0] t);
			rate_result_t r;
			int unsigned s;
			if (z >= ZONES || p >= POTS_PER_ZONE) begin
				r.st = ST_BADIDX;
				r.rate = '0;
				r.count = '0;
			end else begin
				s = z * POTS_PER_ZONE + p;
				if (cmd == 1'b0) begin
					hum_ring[s][wr_pos[s]] = h;
					tms_ring[s][wr_pos[s]] = t;
					wr_pos[s] = (wr_pos[s] + 1) % HISTORY_DEPTH;
					if (held[s] < HISTORY_DEPTH) held[s]++;
					r.st = ST_RECORDED;
				end else begin
					r.st = fit(s);
				end
				r.rate = RATE_W'(rate[s]);
				r.count = CNT_W'(held[s]);
			end
			expected_results.push_back(r);
		endfunction

		function void check_result(logic [STATUS_W-1:0] st, logic [RATE_W-1:0] rt,
				logic [CNT_W-1:0] cnt);
			rate_result_t e;
			if (expected_results.size() == 0) begin
				$error("result item with nothing expected: status %0d", st);
				errors++;
				return;
			end
			e = expected_results.pop_front();
			if (st !== e.st) begin
				$error("status: expected %0d, actual %0d", e.st, st);
				errors++;
			end
			if (rt !== e.rate) begin
				$error("rate_centipct_per_hour: expected %0d, actual %0d", e.rate, rt);
				errors++;
			end
			if (cnt !== e.count) begin
				$error("sample_count: expected %0d, actual %0d", e.count, cnt);
				errors++;
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic                command;
	logic [1:0]          zone;
	logic [3:0]          pot;
	logic [HUM_W-1:0]    humidity;
	logic [TIME_W-1:0]   sample_time_ms;
	logic                out_valid;
	logic                out_ready;
	logic [STATUS_W-1:0] status;
	logic [RATE_W-1:0]   rate_centipct_per_hour;
	logic [CNT_W-1:0]    sample_count;

	drying_rate_book book;
	bit              quiet;      // no idling in the last part of the run
	bit              long_hold;  // request a long receiver stall
	int              stuck_cycles;
	logic [TIME_W-1:0] last_time [SLOTS];

	localparam int ITEMS      = 1450;
	localparam int STUCK_MAX  = 5000;
	localparam int HOLD_LEN   = 400;

	drying_rate_regression dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .zone(zone), .pot(pot),
		.humidity(humidity), .sample_time_ms(sample_time_ms),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .rate_centipct_per_hour(rate_centipct_per_hour),
		.sample_count(sample_count)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Check each accepted result item at the rising edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			book.check_result(status, rate_centipct_per_hour, sample_count);
	end

	// Watchdog: count cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_MAX) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// Receiver: random stall bursts, one long hold-off on request.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				long_hold = 1'b0;
				repeat (HOLD_LEN - 1) @(negedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17) - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offer one item at the falling edge; hold it until accepted.
	task automatic send_item(logic cmd, logic [1:0] z, logic [3:0] p,
			logic [HUM_W-1:0] h, logic [TIME_W-1:0] t);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		zone <= z;
		pot <= p;
		humidity <= h;
		sample_time_ms <= t;
		do @(posedge clk); while (!in_ready);
		book.note_item(cmd, z, p, h, t);
		@(negedge clk);
	endtask

	// Record k samples into one slot, then update it.
	task automatic fit_run(int unsigned s, int k, int unsigned step_max, int trend,
			inout int sent);
		logic [TIME_W-1:0] t;
		int h;
		t = last_time[s];
		h = $urandom_range(0, 255);
		for (int i = 0; i < k; i++) begin
			t = t + TIME_W'($urandom_range(0, step_max));
			h = h + trend + $urandom_range(0, 8) - 4;
			if (h < 0) h = 0;
			if (h > 255) h = 255;
			send_item(1'b0, 2'(s / POTS_PER_ZONE), 4'(s % POTS_PER_ZONE), 8'(h), t);
			sent++;
		end
		last_time[s] = t;
		send_item(1'b1, 2'(s / POTS_PER_ZONE), 4'(s % POTS_PER_ZONE),
			HUM_W'($urandom), TIME_W'($urandom));
		sent++;
	endtask

	initial begin
		int sent;
		int unsigned s, step_max;
		book = new();
		quiet = 1'b0;
		long_hold = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = 1'b0;
		zone = '0;
		pot = '0;
		humidity = '0;
		sample_time_ms = '0;
		for (int i = 0; i < SLOTS; i++) last_time[i] = $urandom;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: bad indices, empty update, degenerate spread, rising and steep fall.
		send_item(1'b0, 2'd3, 4'd0, 8'hff, 32'hffff_ffff);
		send_item(1'b1, 2'd0, 4'd15, 8'h00, 32'h0);
		send_item(1'b1, 2'd2, 4'd9, 8'h00, 32'h0);
		send_item(1'b1, 2'd0, 4'd3, 8'h00, 32'h0);
		for (int i = 0; i < 6; i++)
			send_item(1'b0, 2'd0, 4'd0, 8'(i * 40), 32'h1234_5678);
		send_item(1'b1, 2'd0, 4'd0, 8'h00, 32'h0);
		for (int i = 0; i < 6; i++)
			send_item(1'b0, 2'd1, 4'd9, 8'(10 + i * 20), 32'hfff0_0000 + i * 3600000);
		send_item(1'b1, 2'd1, 4'd9, 8'h00, 32'h0);
		for (int i = 0; i < 6; i++)
			send_item(1'b0, 2'd0, 4'd1, 8'(255 - i * 51), 32'(i * 12000));
		send_item(1'b1, 2'd0, 4'd1, 8'h00, 32'h0);
		sent = 25;
		in_valid <= 1'b0;
		do @(negedge clk); while (book.pending() != 0);

		while (sent < ITEMS) begin
			if (sent > ITEMS * 9 / 10) quiet = 1'b1;
			if (sent >= 300 && sent < 320) long_hold = 1'b1;
			if (sent >= 700 && sent < 720) begin
				// Let the block drain completely before going on.
				in_valid <= 1'b0;
				do @(negedge clk); while (book.pending() != 0);
			end
			if ($urandom_range(0, 9) < 2) begin
				// Noise: any field value, bad indices included.
				send_item(1'($urandom), 2'($urandom), 4'($urandom),
					HUM_W'($urandom), TIME_W'($urandom));
				sent++;
			end else begin
				s = $urandom_range(0, SLOTS - 1);
				case ($urandom_range(0, 4))
					0: step_max = 1000;
					1: step_max = 600000;
					2: step_max = 36000000;
					3: step_max = 32'h7fff_ffff;
					default: step_max = 7200000;
				endcase
				fit_run(s, $urandom_range(1, 12), step_max,
					int'($urandom_range(0, 12)) - 8, sent);
			end
		end
		in_valid <= 1'b0;

		while (book.pending() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (book.errors == 0 && book.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
